/* hw/rtl/move_toward_target_step_defines.svh */
// Assertion macros for the RTL.
`ifndef MOVE_TOWARD_TARGET_STEP_DEFINES_SVH
`define MOVE_TOWARD_TARGET_STEP_DEFINES_SVH

// Checks an implication on every rising clock edge outside reset.
`define MTT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent, outside reset.
`define MTT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/mtt_pkg.sv */
`default_nettype none
package mtt_pkg;
  localparam int CoordW = 32;
  localparam int DiffW  = CoordW + 1;
  localparam int SqW    = 2 * DiffW - 1;
  localparam int RootW  = DiffW;
  localparam int SqrtStages = RootW;
  localparam int TimeW  = 20;
  localparam int SnapW  = 32;
  localparam int SpeedW = 32;
  localparam int NumW   = 2 * DiffW;
  localparam int DivStages = NumW;

  typedef enum logic [1:0] {
    OUT_DEAD = 2'd0,
    OUT_SNAP = 2'd1,
    OUT_STEP = 2'd2
  } outcome_t;

  localparam logic [0:0] REG_TIME_STEP = 1'b0;
  localparam logic [0:0] REG_SNAP      = 1'b1;

  // Item context carried alongside the square root and divide pipelines.
  typedef struct packed {
    logic                     alive;
    logic                     last;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] gx;
    logic signed [CoordW-1:0] gy;
    logic                     nx;
    logic                     ny;
    logic [DiffW-1:0]         ax;
    logic [DiffW-1:0]         ay;
    logic [51:0]              reach;
  } ctx_t;
endpackage
`default_nettype wire

/* hw/rtl/mtt_sqrt.sv */
`default_nettype none
// Pipelined floor square root, one result bit per stage.
module mtt_sqrt
  import mtt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             in_v,
  input  wire logic [SqW-1:0]   in_sq,
  input  wire ctx_t             in_ctx,
  output logic                  out_v,
  output logic [RootW-1:0]      out_root,
  output ctx_t                  out_ctx
);
  logic             v_r    [SqrtStages+1];
  logic [SqW-1:0]   s_r    [SqrtStages+1];
  logic [RootW-1:0] r_r    [SqrtStages+1];
  ctx_t             c_r    [SqrtStages+1];

  always_comb begin
    v_r[0] = in_v;
    s_r[0] = in_sq;
    r_r[0] = '0;
    c_r[0] = in_ctx;
  end

  for (genvar g = 0; g < SqrtStages; g++) begin : g_st
    localparam int B = SqrtStages - 1 - g;
    logic [RootW-1:0]   cand;
    logic [2*RootW-1:0] csq;
    assign cand = r_r[g] | (RootW'(1) << B);
    assign csq  = cand * cand;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else if (adv) begin
        v_r[g+1] <= v_r[g];
      end
      if (adv) begin
        s_r[g+1] <= s_r[g];
        c_r[g+1] <= c_r[g];
        r_r[g+1] <= (csq <= {1'b0, s_r[g]}) ? cand : r_r[g];
      end
    end
  end

  assign out_v    = v_r[SqrtStages];
  assign out_root = r_r[SqrtStages];
  assign out_ctx  = c_r[SqrtStages];
endmodule
`default_nettype wire

/* hw/rtl/move_toward_target_step.sv */
// Pipeline order: inputs, squares, sum, square root, set-up, divider, output.
// One beat per cycle unless a result is held; sqrt and divider fully pipelined.
// A stall on the result side freezes the whole pipeline; nothing is lost.
// Reset (rst_n low at a clock edge) empties the pipeline and loads
// time_step = 1092 and snap_distance = 65536.
`default_nettype none
`include "move_toward_target_step_defines.svh"
module move_toward_target_step
  import mtt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_alive,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_goal_x,
  input  wire logic signed [31:0] in_goal_y,
  input  wire logic [31:0]       in_speed,
  input  wire logic              in_last_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [31:0]     out_new_x,
  output logic signed [31:0]     out_new_y,
  output logic [1:0]             out_outcome,
  output logic                   out_last_out,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [2:0]        cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);
  logic [TimeW-1:0] time_step_r;
  logic [SnapW-1:0] snap_r;
  logic adv;
  logic acc;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= TimeW'(1092);
      snap_r      <= SnapW'(65536);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == REG_TIME_STEP) time_step_r <= cfg_pwdata[TimeW-1:0];
      else                               snap_r      <= cfg_pwdata;
    end
  end
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == REG_TIME_STEP) cfg_prdata = 32'(time_step_r);
      else                               cfg_prdata = snap_r;
    end
  end

  // The whole pipeline advances together unless a finished result is held.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign acc      = in_valid && !in_stall;

  // Stage 1: register inputs and differences; reach product.
  logic       v1_r;
  ctx_t       c1_r;
  logic signed [DiffW-1:0] dx1, dy1;
  assign dx1 = DiffW'(in_goal_x) - DiffW'(in_pos_x);
  assign dy1 = DiffW'(in_goal_y) - DiffW'(in_pos_y);
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= acc;
    if (adv) begin
      c1_r.alive <= in_alive;
      c1_r.last  <= in_last_item;
      c1_r.px    <= in_pos_x;
      c1_r.py    <= in_pos_y;
      c1_r.gx    <= in_goal_x;
      c1_r.gy    <= in_goal_y;
      c1_r.nx    <= dx1[DiffW-1];
      c1_r.ny    <= dy1[DiffW-1];
      c1_r.ax    <= dx1[DiffW-1] ? DiffW'(-dx1) : DiffW'(dx1);
      c1_r.ay    <= dy1[DiffW-1] ? DiffW'(-dy1) : DiffW'(dy1);
      c1_r.reach <= 52'((in_speed * 52'(time_step_r)) >> 16);
    end
  end

  // Stage 2: squares.
  logic v2_r;
  ctx_t c2_r;
  logic [SqW-1:0] sqx2_r, sqy2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      c2_r   <= c1_r;
      sqx2_r <= SqW'(c1_r.ax) * SqW'(c1_r.ax);
      sqy2_r <= SqW'(c1_r.ay) * SqW'(c1_r.ay);
    end
  end

  // Stage 3: sum of squares.
  logic v3_r;
  ctx_t c3_r;
  logic [SqW-1:0] sum3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
    if (adv) begin
      c3_r   <= c2_r;
      sum3_r <= sqx2_r + sqy2_r;
    end
  end

  logic             vs;
  logic [RootW-1:0] root_len;
  ctx_t             cs;
  mtt_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_v(v3_r), .in_sq(sum3_r), .in_ctx(c3_r),
    .out_v(vs), .out_root(root_len), .out_ctx(cs)
  );

  // Decision and product set-up for the two dividers.
  logic [RootW-1:0] step;
  logic             snap;
  assign step = (53'(cs.reach) < 53'(root_len)) ? RootW'(cs.reach) : root_len;
  assign snap = 64'(root_len) < 64'(snap_r);

  logic             v4_r;
  ctx_t             c4_r;
  logic             snap4_r;
  logic [RootW-1:0] dist4_r;
  logic [NumW-1:0]  numx4_r, numy4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= vs;
    if (adv) begin
      c4_r    <= cs;
      snap4_r <= snap;
      dist4_r <= root_len;
      numx4_r <= NumW'(cs.ax) * NumW'(step);
      numy4_r <= NumW'(cs.ay) * NumW'(step);
    end
  end

  // Restoring divide, one quotient bit per stage, both axes side by side.
  logic             dv_r  [DivStages+1];
  ctx_t             dc_r  [DivStages+1];
  logic             ds_r  [DivStages+1];
  logic [RootW-1:0] dd_r  [DivStages+1];
  logic [NumW-1:0]  nx_r  [DivStages+1];
  logic [NumW-1:0]  ny_r  [DivStages+1];
  logic [RootW:0]   rx_r  [DivStages+1];
  logic [RootW:0]   ry_r  [DivStages+1];
  always_comb begin
    dv_r[0] = v4_r; dc_r[0] = c4_r; ds_r[0] = snap4_r; dd_r[0] = dist4_r;
    nx_r[0] = numx4_r; ny_r[0] = numy4_r; rx_r[0] = '0; ry_r[0] = '0;
  end
  for (genvar g = 0; g < DivStages; g++) begin : g_div
    logic [RootW:0] tx, ty;
    logic           kx, ky;
    assign tx = {rx_r[g][RootW-1:0], nx_r[g][NumW-1]};
    assign ty = {ry_r[g][RootW-1:0], ny_r[g][NumW-1]};
    assign kx = tx >= {1'b0, dd_r[g]};
    assign ky = ty >= {1'b0, dd_r[g]};
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[g+1] <= 1'b0;
      else if (adv) dv_r[g+1] <= dv_r[g];
      if (adv) begin
        dc_r[g+1] <= dc_r[g];
        ds_r[g+1] <= ds_r[g];
        dd_r[g+1] <= dd_r[g];
        rx_r[g+1] <= kx ? tx - {1'b0, dd_r[g]} : tx;
        ry_r[g+1] <= ky ? ty - {1'b0, dd_r[g]} : ty;
        nx_r[g+1] <= {nx_r[g][NumW-2:0], kx};
        ny_r[g+1] <= {ny_r[g][NumW-2:0], ky};
      end
    end
  end

  // Output register.
  ctx_t             cf;
  logic [CoordW-1:0] qx, qy;
  logic             zero_d;
  assign cf     = dc_r[DivStages];
  assign qx     = nx_r[DivStages][CoordW-1:0];
  assign qy     = ny_r[DivStages][CoordW-1:0];
  assign zero_d = dd_r[DivStages] == '0;

  logic signed [CoordW-1:0] new_x_nxt, new_y_nxt;
  outcome_t                 outcome_nxt;
  always_comb begin
    new_x_nxt   = cf.px;
    new_y_nxt   = cf.py;
    outcome_nxt = OUT_DEAD;
    if (cf.alive) begin
      if (ds_r[DivStages]) begin
        new_x_nxt   = cf.gx;
        new_y_nxt   = cf.gy;
        outcome_nxt = OUT_SNAP;
      end else begin
        outcome_nxt = OUT_STEP;
        if (!zero_d) begin
          new_x_nxt = cf.nx ? cf.px - qx : cf.px + qx;
          new_y_nxt = cf.ny ? cf.py - qy : cf.py + qy;
        end
      end
    end
  end

  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= dv_r[DivStages];
    if (adv) begin
      out_new_x    <= new_x_nxt;
      out_new_y    <= new_y_nxt;
      out_outcome  <= outcome_nxt;
      out_last_out <= cf.last;
    end
  end
  assign out_valid = out_valid_r;

  `MTT_ASSERT_IMP(a_stall_backpressure, out_valid && out_stall, in_stall,
    "input taken while a result is held")
  `MTT_ASSERT_NXT(a_hold_result, out_valid && out_stall, out_valid,
    "held result dropped")
  `MTT_ASSERT_IMP(a_outcome_code, out_valid,
    out_outcome == OUT_DEAD || out_outcome == OUT_SNAP || out_outcome == OUT_STEP,
    "illegal outcome")
endmodule
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import mtt_pkg::*;

  // Expected position updates, checked in arrival order.
  typedef struct {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    outcome_t           oc;
    logic               last;
  } move_t;

  class move_board;
    move_t pending[$];
    int    errors;
    bit [19:0] tstep;
    bit [31:0] snap;

    function new();
      errors = 0;
      tstep = 20'd1092;
      snap = 32'd65536;
    endfunction

    function automatic bit [63:0] isqrt(bit [127:0] s);
      bit [63:0] r;
      bit [63:0] c;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if ({64'd0, c} * {64'd0, c} <= s) r = c;
      end
      return r;
    endfunction

    function automatic logic signed [63:0] axis_delta(logic signed [63:0] d,
                                                     bit [63:0] stp, bit [63:0] len);
      bit [127:0] q;
      bit [63:0] mag;
      mag = d < 0 ? -d : d;
      q = ({64'd0, mag} * {64'd0, stp}) / {64'd0, len};
      return d < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function void note_unit(logic alive, logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] gx, logic signed [31:0] gy,
                            logic [31:0] spd, logic last);
      move_t m;
      logic signed [63:0] dx, dy, nx, ny;
      bit [63:0] ax, ay, len, reach, stp;
      nx = px;
      ny = py;
      m.oc = OUT_DEAD;
      if (alive) begin
        dx = 64'(gx) - 64'(px);
        dy = 64'(gy) - 64'(py);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        len = isqrt({64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay});
        if (len < {32'd0, snap}) begin
          nx = gx;
          ny = gy;
          m.oc = OUT_SNAP;
        end else begin
          reach = ({32'd0, spd} * {44'd0, tstep}) >> 16;
          stp = reach < len ? reach : len;
          if (len != 0) begin
            nx = px + axis_delta(dx, stp, len);
            ny = py + axis_delta(dy, stp, len);
          end
          m.oc = OUT_STEP;
        end
      end
      m.nx = nx[31:0];
      m.ny = ny[31:0];
      m.last = last;
      pending.push_back(m);
    endfunction

    function void check_move(logic signed [31:0] nx, logic signed [31:0] ny,
                             logic [1:0] oc, logic last);
      move_t m;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat x=%0d y=%0d", nx, ny);
        return;
      end
      m = pending.pop_front();
      if (nx !== m.nx || ny !== m.ny || oc !== m.oc || last !== m.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp x=%0d y=%0d oc=%0d last=%0b, got x=%0d y=%0d oc=%0d last=%0b",
                   m.nx, m.ny, m.oc, m.last, nx, ny, oc, last);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall;
  logic in_alive = 0, in_last_item = 0;
  logic signed [31:0] in_pos_x = 0, in_pos_y = 0, in_goal_x = 0, in_goal_y = 0;
  logic [31:0] in_speed = 0;
  logic out_valid, out_stall = 0;
  logic signed [31:0] out_new_x, out_new_y;
  logic [1:0] out_outcome;
  logic out_last_out;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0] cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0, cfg_prdata;
  logic cfg_pready;

  int idle_pct = 0, stall_pct = 0;
  move_board board = new();

  move_toward_target_step DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_move(out_new_x, out_new_y, out_outcome, out_last_out);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    if (idx == REG_TIME_STEP) board.tstep = val[19:0];
    else board.snap = val;
  endtask

  task automatic send_unit(logic alive, logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [31:0] gx, logic signed [31:0] gy,
                           logic [31:0] spd, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_alive <= alive;
    in_pos_x <= px;
    in_pos_y <= py;
    in_goal_x <= gx;
    in_goal_y <= gy;
    in_speed <= spd;
    in_last_item <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_unit(alive, px, py, gx, gy, spd, last);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (110) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(logic [31:0] base);
    case ($urandom_range(3))
      0: return $urandom;
      1: return base + $signed($urandom_range(4096) - 2048);
      2: return base + $signed($urandom_range(32'h0040_0000) - 32'h0020_0000);
      default: return base + $signed($urandom_range(32'h0800_0000) - 32'h0400_0000);
    endcase
  endfunction

  task automatic random_units(int n);
    logic [31:0] px, py;
    for (int i = 0; i < n; i++) begin
      px = $urandom;
      py = $urandom;
      send_unit($urandom_range(9) != 0, px, py, rand_coord(px), rand_coord(py),
                ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h00ff_ffff),
                $urandom_range(1));
    end
  endtask

  initial begin
    #20_000_000;
    $display("move_toward_target_step test failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed beats at the default settings.
    send_unit(0, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 32'hffff_ffff, 1);
    send_unit(1, 0, 0, 0, 0, 32'd65536, 0);
    send_unit(1, 0, 0, 32'd100, 32'd50, 32'd65536, 1);
    send_unit(1, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
              32'hffff_ffff, 0);
    send_unit(1, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0, 1);
    send_unit(1, 0, 0, 32'h0010_0000, 0, 32'h0001_0000, 0);
    send_unit(1, 0, 0, 32'h0003_0000, 32'hfffc_0000, 32'hffff_ffff, 1);
    send_unit(1, 32'h0001_0000, 0, 32'hfff0_0000, 32'h0100_0000, 32'h0020_0000, 0);
    drain();
    write_reg(REG_SNAP, 0);
    write_reg(REG_TIME_STEP, 20'hfffff);
    send_unit(1, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 5, 1);
    send_unit(1, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0);
    send_unit(1, 0, 0, 32'd3, 32'd4, 32'd1, 1);
    drain();
    write_reg(REG_SNAP, 32'hffff_ffff);
    write_reg(REG_TIME_STEP, 0);
    send_unit(1, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 7, 0);
    send_unit(1, 0, 0, 32'h0100_0000, 32'h0100_0000, 32'hffff_ffff, 1);
    drain();
    write_reg(REG_SNAP, 32'd65536);
    write_reg(REG_TIME_STEP, 20'd1092);
    random_units(250);
    idle_pct = 76;
    random_units(250);
    drain();
    write_reg(REG_TIME_STEP, $urandom_range(20'hfffff));
    write_reg(REG_SNAP, $urandom_range(32'h0010_0000));
    idle_pct = 0;
    stall_pct = 76;
    random_units(300);
    idle_pct = 33;
    stall_pct = 33;
    random_units(300);
    drain();
    write_reg(REG_TIME_STEP, 20'd0);
    write_reg(REG_SNAP, 32'd0);
    idle_pct = 0;
    stall_pct = 0;
    random_units(150);
    drain();
    write_reg(REG_TIME_STEP, 20'hfffff);
    random_units(200);
    drain();
    if (board.errors == 0 && board.pending.size() == 0)
      $display("move_toward_target_step test passed");
    else
      $display("move_toward_target_step test failed");
    $finish;
  end
endmodule
`default_nettype wire
